FILE: sv/ga_bitstring_crossover_defines.svh
// Assertion macros for the checker file of this block.
`ifndef GA_BITSTRING_CROSSOVER_DEFINES_SVH
`define GA_BITSTRING_CROSSOVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GBX_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GBX_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: sv/gbx_pkg.sv
package gbx_pkg;

  // Sizes
  localparam int MAX_STRING   = 64;
  localparam int SWAP_BASIS   = 1024;  // power of two: the draw is masked, not divided
  localparam int RATE_ENTRIES = 4;

  localparam int GENE_W  = $clog2(MAX_STRING);
  localparam int LEN_W   = GENE_W + 1;
  localparam int SWAP_BITS = $clog2(SWAP_BASIS);
  localparam int BIAS_W  = SWAP_BITS + 1;
  localparam int RNG_W   = 32;
  localparam int DVS_W   = 16;
  localparam int THR_W   = 16;
  localparam int PTS_W   = 8;
  localparam int TYPE_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int POOL_DEPTH = MAX_STRING - 1;
  localparam int ENT_W   = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;

  // Crossover modes
  localparam logic [TYPE_W-1:0] MODE_ONE   = 3'd1;
  localparam logic [TYPE_W-1:0] MODE_UNI   = 3'd2;
  localparam logic [TYPE_W-1:0] MODE_NOREP = 3'd3;
  localparam logic [TYPE_W-1:0] MODE_SCALE = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAMILY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 3'd7;

  // Register reset values
  localparam logic [TYPE_W-1:0]         RST_TYPE   = MODE_ONE;
  localparam logic [LEN_W-1:0]          RST_LENGTH = 7'd64;
  localparam logic [BIAS_W-1:0]         RST_BIAS   = 11'd512;
  localparam logic [GENE_W-1:0]         RST_FAMILY = 6'd1;
  localparam logic [DVS_W-1:0]          RST_FREQ   = 16'd1;
  localparam logic [RNG_W-1:0]          RST_SEED   = 32'd1;

  // Divisor selection for the modulo unit
  typedef logic [1:0] gbx_dsel_t;
  localparam gbx_dsel_t DSEL_LEN1   = 2'd0;
  localparam gbx_dsel_t DSEL_POINTS = 2'd1;
  localparam gbx_dsel_t DSEL_FREQ   = 2'd2;
  localparam gbx_dsel_t DSEL_LEN    = 2'd3;

  typedef struct packed {
    logic      take_in;
    logic      div_start;
    gbx_dsel_t div_sel;
    logic      uni_step;
    logic      one_cut;
    logic      nr_begin;
    logic      nr_fill;
    logic      nr_pick;
    logic      pick_rem;
    logic      nr_take;
    logic      nr_put;
    logic      sc_sel;
    logic      sc_mark;
    logic      sc_scan;
    logic      load_out;
  } gbx_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] mode;
    logic              div_done;
    logic              gene_last;
    logic              need_cycle;
    logic              fill_last;
    logic              points_gt1;
    logic              pts_zero;
    logic              cnt_last;
  } gbx_stat_t;

endpackage

FILE: sv/ga_bitstring_crossover.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_stall  | in_parent_a, in_parent_b
// result   | out_valid / out_stall| out_child_a, out_child_b, out_cut_point,
//          |                      | out_points_used
// config   | cfg_we               | cfg_index, cfg_wdata
//
// One item at a time. L is the clamped string length. Every draw that needs a
// modulo goes through one shared restoring divider. A no-repeat item first
// fills the pool when a cycle starts; a scalable item that draws zero points
// is finished as a uniform item.
// The next item is taken while a finished result still waits on out_stall.
// Reset (rst_n low, synchronous) restores the registers and seeds the
// generator; the pool needs no clearing, it is filled at each cycle start.
module ga_bitstring_crossover import gbx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MAX_STRING-1:0] in_parent_a,
  input  logic [MAX_STRING-1:0] in_parent_b,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MAX_STRING-1:0] out_child_a,
  output logic [MAX_STRING-1:0] out_child_b,
  output logic [GENE_W-1:0]     out_cut_point,
  output logic [PTS_W-1:0]      out_points_used,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  gbx_cmd_t  cmd;
  gbx_stat_t stat;

  // Sequence the modes: dispatch, divider waits, gene loops, pool steps
  gbx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold registers, generator, divider, pool and the result register
  gbx_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .parent_a    (in_parent_a),
    .parent_b    (in_parent_b),
    .cmd         (cmd),
    .stat        (stat),
    .child_a     (out_child_a),
    .child_b     (out_child_b),
    .cut_point   (out_cut_point),
    .points_used (out_points_used)
  );

endmodule

FILE: sv/gbx_div.sv
module gbx_div import gbx_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RNG_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(RNG_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RNG_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   shifted;

  // restoring division, one quotient bit per cycle; only the remainder is kept
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, dvd_r[RNG_W-1]};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[RNG_W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(RNG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: sv/gbx_ctrl.sv
module gbx_ctrl import gbx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  gbx_stat_t stat,
  output gbx_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_ONE_W   = 4'd2;
  localparam logic [3:0] S_UNI     = 4'd3;
  localparam logic [3:0] S_NR_FILL = 4'd4;
  localparam logic [3:0] S_NR_PICK = 4'd5;
  localparam logic [3:0] S_NR_W    = 4'd6;
  localparam logic [3:0] S_NR_TAKE = 4'd7;
  localparam logic [3:0] S_NR_PUT  = 4'd8;
  localparam logic [3:0] S_SC_W    = 4'd9;
  localparam logic [3:0] S_SC_CHK  = 4'd10;
  localparam logic [3:0] S_SC_MW   = 4'd11;
  localparam logic [3:0] S_SC_SCAN = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.mode)
          MODE_ONE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_LEN1;
            state_nxt     = S_ONE_W;
          end
          MODE_UNI: state_nxt = S_UNI;
          MODE_NOREP: begin
            if (stat.need_cycle) begin
              cmd.nr_begin = 1'b1;
              state_nxt    = S_NR_FILL;
            end else begin
              state_nxt = S_NR_PICK;
            end
          end
          MODE_SCALE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_FREQ;
            state_nxt     = S_SC_W;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ONE_W: begin
        if (stat.div_done) begin
          cmd.one_cut = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_UNI: begin
        cmd.uni_step = 1'b1;
        if (stat.gene_last) state_nxt = S_DONE;
      end
      S_NR_FILL: begin
        cmd.nr_fill = 1'b1;
        if (stat.fill_last) state_nxt = S_NR_PICK;
      end
      S_NR_PICK: begin
        if (stat.points_gt1) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_POINTS;
          state_nxt     = S_NR_W;
        end else begin
          cmd.nr_pick = 1'b1;
          state_nxt   = S_NR_TAKE;
        end
      end
      S_NR_W: begin
        if (stat.div_done) begin
          cmd.nr_pick  = 1'b1;
          cmd.pick_rem = 1'b1;
          state_nxt    = S_NR_TAKE;
        end
      end
      S_NR_TAKE: begin
        cmd.nr_take = 1'b1;
        state_nxt   = S_NR_PUT;
      end
      S_NR_PUT: begin
        cmd.nr_put = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SC_W: begin
        if (stat.div_done) begin
          cmd.sc_sel = 1'b1;
          state_nxt  = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (stat.pts_zero) begin
          state_nxt = S_UNI;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_LEN;
          state_nxt     = S_SC_MW;
        end
      end
      S_SC_MW: begin
        if (stat.div_done) begin
          cmd.sc_mark = 1'b1;
          if (stat.cnt_last) begin
            state_nxt = S_SC_SCAN;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_LEN;
          end
        end
      end
      S_SC_SCAN: begin
        cmd.sc_scan = 1'b1;
        if (stat.gene_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: sv/gbx_dp.sv
module gbx_dp import gbx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [MAX_STRING-1:0] parent_a,
  input  logic [MAX_STRING-1:0] parent_b,
  input  gbx_cmd_t              cmd,
  output gbx_stat_t             stat,
  output logic [MAX_STRING-1:0] child_a,
  output logic [MAX_STRING-1:0] child_b,
  output logic [GENE_W-1:0]     cut_point,
  output logic [PTS_W-1:0]      points_used
);

  // Genes strictly above cut x; none when x is the top index
  function automatic logic [MAX_STRING-1:0] above_cut(input logic [GENE_W-1:0] x);
    logic [MAX_STRING-1:0] m;
    m = '0;
    if (x < GENE_W'(MAX_STRING - 1)) begin
      m = ~((MAX_STRING'(2) << x) - MAX_STRING'(1));
    end
    return m;
  endfunction

  // Configuration
  logic [TYPE_W-1:0]             type_r;
  logic [LEN_W-1:0]              length_r;
  logic [BIAS_W-1:0]             bias_r;
  logic [GENE_W-1:0]             family_r;
  logic [DVS_W-1:0]              freq_r;
  logic [RATE_ENTRIES*THR_W-1:0] thresh_r;
  logic [RATE_ENTRIES*PTS_W-1:0] counts_r;

  // Generator and no-repeat bookkeeping
  logic [RNG_W-1:0]  rng_r;
  logic [GENE_W-1:0] points_left_r;
  logic [GENE_W-1:0] pairs_left_r;

  // Per-item working registers
  logic [MAX_STRING-1:0] a_r, b_r;
  logic [MAX_STRING-1:0] swapm_r, marks_r;
  logic                  flip_r;
  logic [GENE_W-1:0]     gene_r;
  logic [GENE_W-1:0]     cut_r;
  logic [PTS_W-1:0]      pts_r, cnt_r;
  logic [GENE_W-1:0]     k_r;

  // Point pool
  logic [GENE_W-1:0] pool_mem [0:POOL_DEPTH-1];
  logic [GENE_W-1:0] pool_rdata_r;
  logic [GENE_W-1:0] pool_raddr, pool_waddr, pool_wdata;
  logic              pool_we;

  // Output register
  logic [MAX_STRING-1:0] child_a_r, child_b_r;
  logic [GENE_W-1:0]     cut_out_r;
  logic [PTS_W-1:0]      pts_out_r;

  // Derived values
  logic [RNG_W-1:0]      x1, x2, draw_w;
  logic [LEN_W-1:0]      len_w;
  logic [GENE_W-1:0]     len_m1_w;
  logic [MAX_STRING-1:0] lenmask_w;
  logic [GENE_W-1:0]     fam1_w, fam_w;
  logic [DVS_W-1:0]      divisor_w;
  logic                  div_done;
  logic [DVS_W-1:0]      div_rem;
  logic [ENT_W-1:0]      sel_e;
  logic [PTS_W-1:0]      sel_cnt;
  logic                  uni_swap;
  logic                  flip_nxt;
  logic [GENE_W-1:0]     pick_k;

  assign x1     = rng_r ^ (rng_r << 13);
  assign x2     = x1 ^ (x1 >> 17);
  assign draw_w = x2 ^ (x2 << 5);

  always_comb begin
    if (length_r < LEN_W'(2)) begin
      len_w = LEN_W'(2);
    end else if (length_r > LEN_W'(MAX_STRING)) begin
      len_w = LEN_W'(MAX_STRING);
    end else begin
      len_w = length_r;
    end
  end

  assign len_m1_w  = GENE_W'(len_w - LEN_W'(1));
  assign lenmask_w = ~({MAX_STRING{1'b1}} << len_w);
  assign fam1_w    = (family_r == '0) ? GENE_W'(1) : family_r;
  assign fam_w     = (fam1_w > len_m1_w) ? len_m1_w : fam1_w;

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_LEN1:   divisor_w = DVS_W'(len_m1_w);
      DSEL_POINTS: divisor_w = DVS_W'(points_left_r);
      DSEL_FREQ:   divisor_w = (freq_r == '0) ? DVS_W'(1) : freq_r;
      DSEL_LEN:    divisor_w = DVS_W'(len_w);
      default:     divisor_w = DVS_W'(1);
    endcase
  end

  gbx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (draw_w),
    .divisor  (divisor_w),
    .done     (div_done),
    .rem      (div_rem)
  );

  // first entry whose threshold is not below the draw modulo the frequency, else the last one
  always_comb begin
    sel_e = ENT_W'(RATE_ENTRIES - 1);
    for (int i = RATE_ENTRIES - 1; i >= 0; i--) begin
      if (thresh_r[i*THR_W +: THR_W] >= div_rem) sel_e = ENT_W'(i);
    end
  end

  assign sel_cnt  = counts_r[sel_e*PTS_W +: PTS_W];
  assign uni_swap = ({1'b0, draw_w[SWAP_BITS-1:0]} >= bias_r);
  assign flip_nxt = flip_r ^ marks_r[gene_r];
  assign pick_k   = cmd.pick_rem ? div_rem[GENE_W-1:0] : '0;

  // Configuration registers and generator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r   <= RST_TYPE;
      length_r <= RST_LENGTH;
      bias_r   <= RST_BIAS;
      family_r <= RST_FAMILY;
      freq_r   <= RST_FREQ;
      thresh_r <= '0;
      counts_r <= '0;
      rng_r    <= RST_SEED;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TYPE:   type_r   <= cfg_wdata[TYPE_W-1:0];
          CFG_LENGTH: length_r <= cfg_wdata[LEN_W-1:0];
          CFG_BIAS:   bias_r   <= cfg_wdata[BIAS_W-1:0];
          CFG_FAMILY: family_r <= cfg_wdata[GENE_W-1:0];
          CFG_FREQ:   freq_r   <= cfg_wdata[DVS_W-1:0];
          CFG_THRESH: thresh_r <= cfg_wdata[RATE_ENTRIES*THR_W-1:0];
          CFG_COUNTS: counts_r <= cfg_wdata[RATE_ENTRIES*PTS_W-1:0];
          CFG_SEED:   rng_r    <= cfg_wdata[RNG_W-1:0];
          default: ;
        endcase
      end else if (cmd.div_start || cmd.uni_step) begin
        rng_r <= draw_w;
      end
    end
  end

  // No-repeat counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_left_r <= '0;
      pairs_left_r  <= '0;
    end else if (cmd.nr_begin) begin
      points_left_r <= len_m1_w;
      pairs_left_r  <= fam_w;
    end else if (cmd.nr_take) begin
      points_left_r <= points_left_r - GENE_W'(1);
      pairs_left_r  <= pairs_left_r - GENE_W'(1);
    end
  end

  // Pool memory: one write, one registered read
  always_comb begin
    pool_we    = cmd.nr_fill || cmd.nr_put;
    pool_waddr = cmd.nr_fill ? gene_r : k_r;
    pool_wdata = cmd.nr_fill ? gene_r : pool_rdata_r;
    pool_raddr = cmd.nr_pick ? pick_k : (points_left_r - GENE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
    pool_rdata_r <= pool_mem[pool_raddr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      a_r     <= parent_a;
      b_r     <= parent_b;
      swapm_r <= '0;
      marks_r <= '0;
      flip_r  <= 1'b0;
      gene_r  <= '0;
      cut_r   <= '0;
      pts_r   <= '0;
    end else begin
      if (cmd.uni_step) begin
        swapm_r[gene_r] <= uni_swap;
        gene_r          <= gene_r + GENE_W'(1);
      end
      if (cmd.sc_scan) begin
        swapm_r[gene_r] <= flip_nxt;
        flip_r          <= flip_nxt;
        gene_r          <= gene_r + GENE_W'(1);
      end
      if (cmd.nr_begin) gene_r <= '0;
      if (cmd.nr_fill) gene_r <= gene_r + GENE_W'(1);
      if (cmd.one_cut) begin
        cut_r   <= div_rem[GENE_W-1:0];
        swapm_r <= above_cut(div_rem[GENE_W-1:0]);
        pts_r   <= PTS_W'(1);
      end
      if (cmd.nr_pick) k_r <= pick_k;
      if (cmd.nr_take) begin
        cut_r   <= pool_rdata_r;
        swapm_r <= above_cut(pool_rdata_r);
        pts_r   <= PTS_W'(1);
      end
      if (cmd.sc_sel) begin
        pts_r <= sel_cnt;
        cnt_r <= sel_cnt;
      end
      if (cmd.sc_mark) begin
        marks_r[div_rem[GENE_W-1:0]] <= 1'b1;
        cnt_r                        <= cnt_r - PTS_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      child_a_r <= ((a_r & ~swapm_r) | (b_r & swapm_r)) & lenmask_w;
      child_b_r <= ((b_r & ~swapm_r) | (a_r & swapm_r)) & lenmask_w;
      cut_out_r <= cut_r;
      pts_out_r <= pts_r;
    end
  end

  assign stat.mode       = type_r;
  assign stat.div_done   = div_done;
  assign stat.gene_last  = (gene_r == len_m1_w);
  assign stat.need_cycle = (pairs_left_r == '0) || (points_left_r == '0);
  assign stat.fill_last  = (gene_r == (points_left_r - GENE_W'(1)));
  assign stat.points_gt1 = (points_left_r > GENE_W'(1));
  assign stat.pts_zero   = (pts_r == '0);
  assign stat.cnt_last   = (cnt_r == PTS_W'(1));

  assign child_a     = child_a_r;
  assign child_b     = child_b_r;
  assign cut_point   = cut_out_r;
  assign points_used = pts_out_r;

endmodule

FILE: sv/gbx_chk.sv
`include "ga_bitstring_crossover_defines.svh"

module gbx_chk import gbx_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [MAX_STRING-1:0] out_child_a,
  input logic [MAX_STRING-1:0] out_child_b,
  input logic [GENE_W-1:0]     out_cut_point,
  input logic [PTS_W-1:0]      out_points_used
);

  logic [2*MAX_STRING+GENE_W+PTS_W-1:0] out_item;

  assign out_item = {out_child_a, out_child_b, out_cut_point, out_points_used};

  // a stalled result holds still
  `GBX_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // only one item in work: after an accept the input side stalls
  `GBX_CHECK_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // a cut point is reported only by the one-point modes
  `GBX_CHECK_NOW(a_cut_one_point, out_valid, (out_cut_point == '0) || (out_points_used == PTS_W'(1)))

endmodule

bind ga_bitstring_crossover gbx_chk u_gbx_chk (.*);
